// ===== rtl/core/ujse_pkg.sv =====
package ujse_pkg;

  localparam int unsigned POS_W      = 16;
  localparam int unsigned ERR_POS_W  = 16;
  localparam int unsigned RUN_MAX    = 6;
  localparam int unsigned RUN_IDX_W  = 3;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;

  localparam logic [7:0] CHR_QUOTE  = 8'h22;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_U      = 8'h75;
  localparam logic [7:0] CHR_SPACE  = 8'h20;

  typedef enum logic [1:0] {
    ACT_OPEN   = 2'd0,
    ACT_DATA   = 2'd1,
    ACT_CLOSE  = 2'd2,
    ACT_UNUSED = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_STRING = 2'd1,
    MODE_ERROR  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ERR_BAD_LEAD = 2'd0,
    ERR_BAD_CONT = 2'd1,
    ERR_BAD_CP   = 2'd2,
    ERR_TRUNC    = 2'd3
  } err_kind_e;

  // one run of results caused by one transaction
  typedef struct packed {
    logic [RUN_IDX_W-1:0]    len;
    logic [RUN_MAX-1:0][7:0] bytes;
    logic                    is_err;
    logic [1:0]              kind;
    logic [ERR_POS_W-1:0]    pos;
  } run_t;

  typedef struct packed {
    logic valid;
    run_t run;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CHR_ZERO + {4'h0, v};
    end else begin
      r = 8'h57 + {4'h0, v};
    end
    return r;
  endfunction

  function automatic logic [ERR_POS_W-1:0] sat_pos(input logic [POS_W-1:0] p);
    logic [ERR_POS_W-1:0] r;
    if (64'(p) > 64'(16'hFFFF)) begin
      r = ERR_POS_W'(16'hFFFF);
    end else begin
      r = ERR_POS_W'(p);
    end
    return r;
  endfunction

  function automatic run_t byte_run(input logic [7:0] b);
    run_t r;
    r          = '0;
    r.len      = RUN_IDX_W'(1);
    r.bytes[0] = b;
    return r;
  endfunction

  function automatic run_t err_run(input err_kind_e k, input logic [POS_W-1:0] p);
    run_t r;
    r        = '0;
    r.len    = RUN_IDX_W'(1);
    r.is_err = 1'b1;
    r.kind   = k;
    r.pos    = sat_pos(p);
    return r;
  endfunction

  function automatic run_t pair_run(input logic [7:0] b);
    run_t r;
    r          = '0;
    r.len      = RUN_IDX_W'(2);
    r.bytes[0] = CHR_BSLASH;
    r.bytes[1] = b;
    return r;
  endfunction

  function automatic run_t escape_ascii(input logic [7:0] b);
    run_t r;
    r = byte_run(b);
    unique case (b)
      8'h22:   r = pair_run(CHR_QUOTE);
      8'h5C:   r = pair_run(CHR_BSLASH);
      8'h08:   r = pair_run(8'h62);
      8'h09:   r = pair_run(8'h74);
      8'h0A:   r = pair_run(8'h6E);
      8'h0C:   r = pair_run(8'h66);
      8'h0D:   r = pair_run(8'h72);
      default: begin
        if (b < CHR_SPACE) begin
          r          = '0;
          r.len      = RUN_IDX_W'(6);
          r.bytes[0] = CHR_BSLASH;
          r.bytes[1] = CHR_U;
          r.bytes[2] = CHR_ZERO;
          r.bytes[3] = CHR_ZERO;
          r.bytes[4] = hex_digit(b[7:4]);
          r.bytes[5] = hex_digit(b[3:0]);
        end
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/ujse_in_if.sv =====
interface ujse_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

// ===== rtl/core/ujse_out_if.sv =====
interface ujse_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_error;
  logic [1:0]  error_kind;
  logic [15:0] error_position;
  logic        last_of_run;

  modport source (
    output valid, output out_byte, output is_error, output error_kind,
    output error_position, output last_of_run, input ready
  );
  modport sink (
    input valid, input out_byte, input is_error, input error_kind,
    input error_position, input last_of_run, output ready
  );
endinterface

// ===== rtl/core/ujse_front.sv =====
module ujse_front
  import ujse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ujse_in_if.sink     in_i,
  input  fifo_stat_t  stat_i,
  output push_t       push_o
);

  localparam logic [POS_W-1:0] POS_MAX = '1;

  mode_e            mode_q, mode_d;
  logic [2:0]       exp_q, exp_d;
  logic [1:0]       rc_q, rc_d;
  logic [7:0]       held_q [3];
  logic [7:0]       held_d [3];
  logic [20:0]      acc_q, acc_d;
  logic [POS_W-1:0] cnt_q, cnt_d;
  logic [POS_W-1:0] lead_q, lead_d;

  logic             accept;
  logic             set_str, set_err, set_idle;
  logic [7:0]       b;
  logic [20:0]      acc_sh;
  logic [POS_W-1:0] cnt_inc;
  logic             bad_cp;
  run_t             run;
  logic             push;

  assign in_i.ready = !stat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;
  assign acc_sh     = {acc_q[14:0], b[5:0]};
  assign cnt_inc    = (cnt_q == POS_MAX) ? cnt_q : cnt_q + POS_W'(1);
  assign bad_cp     = (exp_q == 3'd3 && acc_sh < 21'h800)
                   || (exp_q == 3'd4 && acc_sh < 21'h10000)
                   || (acc_sh >= 21'hD800 && acc_sh <= 21'hDFFF)
                   || (acc_sh > 21'h10FFFF);

  always_comb begin
    exp_d    = exp_q;
    rc_d     = rc_q;
    held_d   = held_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    lead_d   = lead_q;
    run      = '0;
    push     = 1'b0;
    set_str  = 1'b0;
    set_err  = 1'b0;
    set_idle = 1'b0;
    if (accept) begin
      unique case (action_e'(in_i.action))
        ACT_OPEN: begin
          set_str = 1'b1;
          exp_d   = '0;
          rc_d    = '0;
          acc_d   = '0;
          cnt_d   = '0;
          lead_d  = '0;
          run     = byte_run(CHR_QUOTE);
          push    = 1'b1;
        end
        ACT_DATA: begin
          if (mode_q == MODE_STRING) begin
            cnt_d = cnt_inc;
            if (exp_q == 3'd0) begin
              if (b < 8'h80) begin
                run  = escape_ascii(b);
                push = 1'b1;
              end else if (b >= 8'hC2 && b <= 8'hF4) begin
                if (b <= 8'hDF) begin
                  exp_d = 3'd2;
                  acc_d = {16'h0, b[4:0]};
                end else if (b <= 8'hEF) begin
                  exp_d = 3'd3;
                  acc_d = {17'h0, b[3:0]};
                end else begin
                  exp_d = 3'd4;
                  acc_d = {18'h0, b[2:0]};
                end
                held_d[0] = b;
                rc_d      = 2'd1;
                lead_d    = cnt_q;
              end else begin
                run     = err_run(ERR_BAD_LEAD, cnt_q);
                push    = 1'b1;
                set_err = 1'b1;
              end
            end else if (b[7:6] != 2'b10) begin
              exp_d   = '0;
              rc_d    = '0;
              acc_d   = '0;
              set_err = 1'b1;
              run     = err_run(ERR_BAD_CONT, cnt_q);
              push    = 1'b1;
            end else begin
              acc_d = acc_sh;
              if ({1'b0, rc_q} + 3'd1 < exp_q) begin
                unique case (rc_q)
                  2'd0:    held_d[0] = b;
                  2'd1:    held_d[1] = b;
                  default: held_d[2] = b;
                endcase
                if (rc_q < 2'd3) begin
                  rc_d = rc_q + 2'd1;
                end
              end else begin
                exp_d = '0;
                rc_d  = '0;
                acc_d = '0;
                push  = 1'b1;
                if (bad_cp) begin
                  set_err = 1'b1;
                  run     = err_run(ERR_BAD_CP, lead_q);
                end else begin
                  run          = '0;
                  run.len      = RUN_IDX_W'(exp_q);
                  run.bytes[0] = held_q[0];
                  unique case (exp_q)
                    3'd2: run.bytes[1] = b;
                    3'd3: begin
                      run.bytes[1] = held_q[1];
                      run.bytes[2] = b;
                    end
                    default: begin
                      run.bytes[1] = held_q[1];
                      run.bytes[2] = held_q[2];
                      run.bytes[3] = b;
                    end
                  endcase
                end
              end
            end
          end
        end
        ACT_CLOSE: begin
          if (mode_q == MODE_STRING) begin
            if (exp_q != 3'd0) begin
              run = err_run(ERR_TRUNC, lead_q);
            end else begin
              run = byte_run(CHR_QUOTE);
            end
            push     = 1'b1;
            exp_d    = '0;
            rc_d     = '0;
            acc_d    = '0;
            set_idle = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    mode_d = mode_q;
    if (set_str) begin
      mode_d = MODE_STRING;
    end else if (set_err) begin
      mode_d = MODE_ERROR;
    end else if (set_idle) begin
      mode_d = MODE_IDLE;
    end
  end

  always_comb begin
    push_o.valid = push;
    push_o.run   = run;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      exp_q  <= '0;
      rc_q   <= '0;
      acc_q  <= '0;
      cnt_q  <= '0;
      lead_q <= '0;
    end else begin
      mode_q <= mode_d;
      exp_q  <= exp_d;
      rc_q   <= rc_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      lead_q <= lead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

  // a pending sequence only exists inside a string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_q != 3'd0) |-> (mode_q == MODE_STRING))
    else $error("sequence pending outside a string");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.valid && push_o.run.is_err) |=> (mode_q != MODE_STRING))
    else $error("error reported but string still open");

endmodule

// ===== rtl/core/ujse_fifo.sv =====
module ujse_fifo
  import ujse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  push_t      push_i,
  input  logic       pop_i,
  output run_t       head_o,
  output fifo_stat_t stat_o
);

  run_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_PTR_W:0]   cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign stat_o.full  = (cnt_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i.valid && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (FIFO_PTR_W + 1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (FIFO_PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= wr_q + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + FIFO_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.run;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i.valid && stat_o.full))
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[FIFO_PTR_W-1:0] == wr_q - rd_q)
    else $error("queue count out of step with pointers");

endmodule

// ===== rtl/core/ujse_back.sv =====
module ujse_back
  import ujse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  run_t       head_i,
  input  fifo_stat_t stat_i,
  output logic       pop_o,
  ujse_out_if.source out_o
);

  logic [RUN_IDX_W-1:0] idx_q, idx_d;
  logic                 valid_q, valid_d;
  logic [7:0]           byte_q;
  logic                 err_q;
  logic [1:0]           kind_q;
  logic [ERR_POS_W-1:0] pos_q;
  logic                 last_q;
  logic                 load, take, run_end;

  assign load    = !valid_q || out_o.ready;
  assign take    = load && !stat_i.empty;
  assign run_end = (idx_q == head_i.len - RUN_IDX_W'(1));
  assign pop_o   = take && run_end;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = !stat_i.empty;
    end
    if (take) begin
      idx_d = run_end ? '0 : idx_q + RUN_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= head_i.bytes[idx_q];
      err_q  <= head_i.is_err;
      kind_q <= head_i.kind;
      pos_q  <= head_i.pos;
      last_q <= run_end;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.out_byte       = byte_q;
  assign out_o.is_error       = err_q;
  assign out_o.error_kind     = kind_q;
  assign out_o.error_position = pos_q;
  assign out_o.last_of_run    = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.is_error) |-> out_o.last_of_run)
    else $error("error transaction not closing its run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != '0) |-> !stat_i.empty)
    else $error("run index advanced with queue empty");

endmodule

// ===== rtl/core/utf8_checked_json_string_escaper.sv =====
// JSON string escaper with UTF-8 checking. Send an open transaction, then one
// data transaction per byte, then a close; open and close each yield a quote,
// data bytes come out escaped or, for multi-byte UTF-8, held until the sequence
// is complete and checked, then copied. The first error in a string yields one
// flagged result and the rest of that string is dropped. Input is taken at one
// transaction per cycle while the four-run queue between the classifier and
// the output serializer is not full (ready does not look ahead to a pop in the
// same cycle); the serializer delivers one result per cycle while the output
// is ready, and a transaction makes up to six results, or none. The first
// result of a transaction passes through the queue and the serializer's output
// register before it is presented. last_of_run marks the final result of each
// transaction.
module utf8_checked_json_string_escaper
  import ujse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  ujse_in_if.sink    in_i,
  ujse_out_if.source out_o
);

  push_t      push;
  fifo_stat_t stat;
  run_t       head;
  logic       pop;

  ujse_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .stat_i (stat),
    .push_o (push)
  );

  ujse_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (stat)
  );

  ujse_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .stat_i (stat),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

// ===== sim/utf8_checked_json_string_escaper_tb.sv =====
`timescale 1ns / 100ps

module utf8_checked_json_string_escaper_tb;
  import ujse_pkg::*;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_error;
    logic [1:0]  kind;
    logic [15:0] position;
    logic        last;
  } esc_result_t;

  class escape_scoreboard;
    mode_e       mode;
    int unsigned seq_len;
    int unsigned seq_got;
    logic [7:0]  held [3];
    logic [20:0] code_acc;
    logic [15:0] byte_pos;
    logic [15:0] lead_pos;
    esc_result_t pending[$];
    int unsigned failures;

    function new();
      mode     = MODE_IDLE;
      seq_len  = 0;
      seq_got  = 0;
      code_acc = '0;
      byte_pos = '0;
      lead_pos = '0;
      failures = 0;
    endfunction

    function void push_byte(logic [7:0] b);
      esc_result_t r;
      r          = '0;
      r.out_byte = b;
      pending    = {pending, r};
    endfunction

    function void push_error(err_kind_e k, logic [15:0] p);
      esc_result_t r;
      r          = '0;
      r.is_error = 1'b1;
      r.kind     = k;
      r.position = p;
      pending    = {pending, r};
      mode = MODE_ERROR;
    endfunction

    function void clear_seq();
      seq_len  = 0;
      seq_got  = 0;
      code_acc = '0;
    endfunction

    function void bump_pos();
      if (byte_pos != 16'hFFFF) begin
        byte_pos++;
      end
    endfunction

    function void take_data(logic [7:0] b);
      logic [15:0] here;
      logic [20:0] cp;
      string       hex;
      bit          bad;
      here = byte_pos;
      hex  = "0123456789abcdef";
      if (seq_len == 0) begin
        if (b < 8'h80) begin
          case (b)
            CHR_QUOTE, CHR_BSLASH: begin
              push_byte(CHR_BSLASH);
              push_byte(b);
            end
            8'h08: begin
              push_byte(CHR_BSLASH);
              push_byte("b");
            end
            8'h09: begin
              push_byte(CHR_BSLASH);
              push_byte("t");
            end
            8'h0A: begin
              push_byte(CHR_BSLASH);
              push_byte("n");
            end
            8'h0C: begin
              push_byte(CHR_BSLASH);
              push_byte("f");
            end
            8'h0D: begin
              push_byte(CHR_BSLASH);
              push_byte("r");
            end
            default: begin
              if (b < CHR_SPACE) begin
                push_byte(CHR_BSLASH);
                push_byte(CHR_U);
                push_byte(CHR_ZERO);
                push_byte(CHR_ZERO);
                push_byte(hex[b[7:4]]);
                push_byte(hex[b[3:0]]);
              end else begin
                push_byte(b);
              end
            end
          endcase
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          seq_len  = 2;
          code_acc = 21'(b[4:0]);
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          seq_len  = 3;
          code_acc = 21'(b[3:0]);
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          seq_len  = 4;
          code_acc = 21'(b[2:0]);
        end else begin
          push_error(ERR_BAD_LEAD, here);
        end
        if (seq_len != 0) begin
          held[0]  = b;
          seq_got  = 1;
          lead_pos = here;
        end
        bump_pos();
      end else begin
        bump_pos();
        if (b[7:6] != 2'b10) begin
          clear_seq();
          push_error(ERR_BAD_CONT, here);
        end else begin
          code_acc = {code_acc[14:0], b[5:0]};
          if (seq_got + 1 < seq_len) begin
            held[seq_got] = b;
            seq_got++;
          end else begin
            cp  = code_acc;
            bad = (seq_len == 3 && cp < 21'h800) || (seq_len == 4 && cp < 21'h10000) ||
                  (cp >= 21'hD800 && cp <= 21'hDFFF) || cp > 21'h10FFFF;
            if (bad) begin
              push_error(ERR_BAD_CP, lead_pos);
            end else begin
              for (int i = 0; i < seq_len - 1; i++) begin
                push_byte(held[i]);
              end
              push_byte(b);
            end
            clear_seq();
          end
        end
      end
    endfunction

    // returns 1 when the transaction is one the block acts on
    function bit note_input(action_e a, logic [7:0] b);
      int unsigned before_n;
      bit          counted;
      before_n = pending.size();
      counted  = (a == ACT_OPEN) || (a != ACT_UNUSED && mode == MODE_STRING);
      case (a)
        ACT_OPEN: begin
          mode = MODE_STRING;
          clear_seq();
          byte_pos = '0;
          lead_pos = '0;
          push_byte(CHR_QUOTE);
        end
        ACT_DATA: begin
          if (mode == MODE_STRING) begin
            take_data(b);
          end
        end
        ACT_CLOSE: begin
          if (mode == MODE_STRING) begin
            if (seq_len != 0) begin
              push_error(ERR_TRUNC, lead_pos);
            end else begin
              push_byte(CHR_QUOTE);
            end
            clear_seq();
            mode = MODE_IDLE;
          end
        end
        default: begin
        end
      endcase
      if (pending.size() > before_n) begin
        pending[pending.size() - 1].last = 1'b1;
      end
      return counted;
    endfunction

    function void mismatch(string field, int unsigned want_v, int unsigned got_v);
      failures++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
    endfunction

    function void check_result(esc_result_t got);
      esc_result_t want;
      if (pending.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, actual byte %h err %b kind %0d pos %0d",
                 $time, got.out_byte, got.is_error, got.kind, got.position);
      end else begin
        want = pending.pop_front();
        if (got.out_byte !== want.out_byte) mismatch("out_byte", want.out_byte, got.out_byte);
        if (got.is_error !== want.is_error) mismatch("is_error", want.is_error, got.is_error);
        if (got.kind !== want.kind) mismatch("error_kind", want.kind, got.kind);
        if (got.position !== want.position) mismatch("error_position", want.position, got.position);
        if (got.last !== want.last) mismatch("last_of_run", want.last, got.last);
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ujse_in_if  in_bus ();
  ujse_out_if out_bus ();

  utf8_checked_json_string_escaper uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus.sink),
    .out_o  (out_bus.source)
  );

  escape_scoreboard sb;
  int unsigned      items;
  int unsigned      string_count;
  bit               in_no_idle;
  bit               out_no_idle;

  always #5 clk_i = ~clk_i;

  task automatic send(action_e a, logic [7:0] b);
    int unsigned gap;
    gap = in_no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.action    <= a;
    in_bus.data_byte <= b;
    do @(posedge clk_i); while (!in_bus.ready);
    void'(sb.note_input(a, b));
    items++;
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
  endtask

  // first keep bytes of cp encoded in len bytes
  task automatic send_utf8(logic [20:0] cp, int unsigned len, int unsigned keep);
    logic [7:0] seq [4];
    case (len)
      2: seq[0] = {3'b110, cp[10:6]};
      3: seq[0] = {4'b1110, cp[15:12]};
      default: seq[0] = {5'b11110, cp[20:18]};
    endcase
    for (int i = 1; i < len; i++) begin
      seq[i] = {2'b10, cp[6 * (len - 1 - i) +: 6]};
    end
    for (int i = 0; i < keep; i++) begin
      send(ACT_DATA, seq[i]);
    end
  endtask

  function automatic logic [20:0] valid_code(int unsigned len);
    logic [20:0] lo;
    logic [20:0] hi;
    logic [20:0] cp;
    case (len)
      2: begin
        lo = 21'h80;
        hi = 21'h7FF;
      end
      3: begin
        lo = 21'h800;
        hi = 21'hFFFF;
      end
      default: begin
        lo = 21'h10000;
        hi = 21'h10FFFF;
      end
    endcase
    case ($urandom_range(0, 7))
      0: cp = lo;
      1: cp = hi;
      default: cp = lo + 21'($urandom_range(0, hi - lo));
    endcase
    if (cp >= 21'hD800 && cp <= 21'hDFFF) begin
      cp = cp ^ 21'h4000;
    end
    return cp;
  endfunction

  task automatic send_string();
    int unsigned pieces;
    int unsigned kind;
    int unsigned len;
    logic [20:0] cp;
    logic [7:0]  b;
    in_no_idle  = ($urandom_range(0, 3) == 0);
    out_no_idle = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) == 0) begin
      send($urandom_range(0, 1) ? ACT_DATA : ACT_CLOSE, 8'($urandom));
    end
    send(ACT_OPEN, 8'($urandom));
    pieces = $urandom_range(0, 8);
    repeat (pieces) begin
      kind = $urandom_range(0, 99);
      len  = $urandom_range(2, 4);
      if (kind < 40) begin
        b = 8'($urandom_range(0, 127));
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 3))
            0: b = CHR_QUOTE;
            1: b = CHR_BSLASH;
            2: b = 8'($urandom_range(0, 31));
            default: b = 8'h7F;
          endcase
        end
        send(ACT_DATA, b);
      end else if (kind < 70) begin
        send_utf8(valid_code(len), len, len);
      end else if (kind < 74) begin
        b = 8'($urandom_range(0, 1) ? $urandom_range(8'h80, 8'hC1)
                                    : $urandom_range(8'hF5, 8'hFF));
        send(ACT_DATA, b);
      end else if (kind < 79) begin
        send_utf8(valid_code(len), len, $urandom_range(1, len - 1));
        b = 8'($urandom);
        if (b[7:6] == 2'b10) begin
          b[6] = 1'b1;
        end
        send(ACT_DATA, b);
      end else if (kind < 85) begin
        case ($urandom_range(0, 3))
          0: send_utf8(21'($urandom_range(0, 21'h7FF)), 3, 3);
          1: send_utf8(21'($urandom_range(0, 21'hFFFF)), 4, 4);
          2: send_utf8(21'($urandom_range(21'hD800, 21'hDFFF)), 3, 3);
          default: send_utf8(21'($urandom_range(21'h110000, 21'h13FFFF)), 4, 4);
        endcase
      end else if (kind < 88) begin
        send_utf8(valid_code(len), len, $urandom_range(1, len - 1));
        send(ACT_CLOSE, 8'($urandom));
      end else if (kind < 91) begin
        if ($urandom_range(0, 1)) begin
          send_utf8(valid_code(len), len, $urandom_range(1, len - 1));
        end
        send(ACT_OPEN, 8'($urandom));
      end else if (kind < 94) begin
        send(ACT_UNUSED, 8'($urandom));
      end else begin
        send(ACT_DATA, 8'($urandom));
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      send(ACT_CLOSE, 8'($urandom));
    end
  endtask

  initial begin
    logic [7:0] ascii_edges [10];
    sb               = new();
    items            = 0;
    string_count     = 0;
    in_no_idle       = 1'b0;
    out_no_idle      = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.action    = ACT_OPEN;
    in_bus.data_byte = 8'h00;
    ascii_edges = '{8'h00, 8'h1F, 8'h22, 8'h5C, 8'h08, 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h7F};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle input, escapes, multibyte limits, truncation
    send(ACT_CLOSE, 8'h00);
    send(ACT_DATA, 8'h41);
    send(ACT_OPEN, 8'hFF);
    foreach (ascii_edges[i]) begin
      send(ACT_DATA, ascii_edges[i]);
    end
    send_utf8(21'h80, 2, 2);
    send_utf8(21'h10FFFF, 4, 4);
    send(ACT_UNUSED, 8'h55);
    send(ACT_CLOSE, 8'h00);
    send(ACT_OPEN, 8'h00);
    send(ACT_DATA, 8'hE0);
    send(ACT_DATA, 8'h80);
    send(ACT_CLOSE, 8'hAA);
    drain();

    while (items < 245) begin
      send_string();
      string_count++;
      if (string_count % 12 == 0) begin
        drain();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    esc_result_t got;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = out_no_idle ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
      got.out_byte = out_bus.out_byte;
      got.is_error = out_bus.is_error;
      got.kind     = out_bus.error_kind;
      got.position = out_bus.error_position;
      got.last     = out_bus.last_of_run;
      sb.check_result(got);
    end
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== utf8_checked_json_string_escaper.f =====
rtl/core/ujse_pkg.sv
rtl/core/ujse_in_if.sv
rtl/core/ujse_out_if.sv
rtl/core/ujse_front.sv
rtl/core/ujse_fifo.sv
rtl/core/ujse_back.sv
rtl/core/utf8_checked_json_string_escaper.sv
sim/utf8_checked_json_string_escaper_tb.sv
